/* design/hmdc_pkg.sv */
`default_nettype none

package hmdc_pkg;

  // longest hmp delta the block rewrites, in bytes
  localparam int unsigned MaxDeltaBytes = 5;
  localparam int unsigned IdxW          = $clog2(MaxDeltaBytes);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned RemW          = 32;

  localparam logic [7:0] StatusMin  = 8'h80;
  localparam logic [7:0] SystemMin  = 8'hf0;
  localparam logic [7:0] MetaStatus = 8'hff;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_CHAN,
    PH_MTYPE,
    PH_MLEN,
    PH_MBODY,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_TRUNC      = 3'd1,
    ERR_NO_STATUS  = 3'd2,
    ERR_SYSEX      = 3'd3,
    ERR_DELTA_LONG = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       track_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       track_done;
    logic [2:0] error_code;
  } out_t;

  // one queued run of results: a single byte, a raw flush or a delta rewrite
  typedef struct packed {
    logic [MaxDeltaBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]               last_idx;
    logic                          rewrite;
    logic                          track_last;
    err_e                          err;
  } job_t;

  // data bytes after a channel status, indexed by status bits 6:4
  function automatic logic [1:0] chan_data_len(input logic [2:0] kind);
    logic [1:0] len;
    case (kind)
      3'd4, 3'd5: len = 2'd1;
      default:    len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* design/hmp_to_midi_delta_converter_unit.sv */
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i  (in_byte, track_last)
// out     | output    | out_valid_o/out_ready_i | out_data_o (out_byte, last_of_run,
//         |           |                         |   track_done, error_code)
//
// the front takes one byte per cycle while the two-entry run queue has room;
// delta bytes with bit 7 clear are held in the front until the delta ends or is cut.
// the back sends one result per cycle while out_ready_i is high; a byte has
// one result for event bytes and n for the end of an n-byte delta (<= 5).
// a result passes the run queue and the output register before it is offered.
// rst_ni clears the parse state, the queue and the output valid at once.
// a stalled output fills the queue, then in_ready_o drops.
`default_nettype none

module hmp_to_midi_delta_converter_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hmdc_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hmdc_pkg::out_t     out_data_o
);
  import hmdc_pkg::*;

  logic push;
  job_t job;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t head;

  hmdc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job)
  );

  hmdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  hmdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* design/hmdc_front.sv */
`default_nettype none

module hmdc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire hmdc_pkg::in_t in_data_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output hmdc_pkg::job_t     job_o
);
  import hmdc_pkg::*;

  phase_e                   phase_q, phase_d;
  logic [IdxW-1:0]          hcnt_q, hcnt_d;
  logic [RemW-1:0]          rem_q, rem_d;
  err_e                     err_q, err_d;
  logic [7:0]               held_q [MaxDeltaBytes];

  logic                     accept;
  logic [7:0]               b;
  logic                     last;
  logic                     emit;
  logic                     use_delta;
  logic                     rewrite;
  logic                     hold_we;
  err_e                     err_n;
  logic [RemW-1:0]          rem_dec;
  logic [RemW-1:0]          rem_len;
  logic [MaxDeltaBytes-1:0][7:0] delta_bytes;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign b          = in_data_i.in_byte;
  assign last       = in_data_i.track_last;
  assign rem_dec    = (rem_q != '0) ? rem_q - RemW'(1) : '0;
  assign rem_len    = {rem_q[RemW-8:0], b[6:0]};

  // held bytes with the incoming byte in the next free slot
  always_comb begin
    for (int i = 0; i < MaxDeltaBytes; i++) begin
      delta_bytes[i] = (IdxW'(i) == hcnt_q) ? b : held_q[i];
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hcnt_d    = hcnt_q;
    rem_d     = rem_q;
    err_n     = err_q;
    emit      = 1'b0;
    use_delta = 1'b0;
    rewrite   = 1'b0;
    hold_we   = 1'b0;

    case (phase_q)
      PH_DELTA: begin
        if (!b[7]) begin
          if (hcnt_q == IdxW'(MaxDeltaBytes - 1)) begin
            emit      = 1'b1;
            use_delta = 1'b1;
            err_n     = ERR_DELTA_LONG;
            phase_d   = PH_ERROR;
            hcnt_d    = '0;
          end else begin
            hold_we = 1'b1;
            hcnt_d  = hcnt_q + IdxW'(1);
            if (last) begin
              emit      = 1'b1;
              use_delta = 1'b1;
              err_n     = ERR_TRUNC;
              phase_d   = PH_ERROR;
            end
          end
        end else begin
          emit      = 1'b1;
          use_delta = 1'b1;
          rewrite   = 1'b1;
          phase_d   = PH_STATUS;
          hcnt_d    = '0;
        end
      end
      PH_STATUS: begin
        emit = 1'b1;
        if (b < StatusMin) begin
          err_n   = ERR_NO_STATUS;
          phase_d = PH_ERROR;
        end else if (b < SystemMin) begin
          rem_d   = RemW'(chan_data_len(b[6:4]));
          phase_d = PH_CHAN;
        end else if (b == MetaStatus) begin
          phase_d = PH_MTYPE;
        end else begin
          err_n   = ERR_SYSEX;
          phase_d = PH_ERROR;
        end
      end
      PH_CHAN, PH_MBODY: begin
        emit  = 1'b1;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d = PH_DELTA;
        end
      end
      PH_MTYPE: begin
        emit    = 1'b1;
        rem_d   = '0;
        phase_d = PH_MLEN;
      end
      PH_MLEN: begin
        emit  = 1'b1;
        rem_d = rem_len;
        if (!b[7]) begin
          phase_d = (rem_len != '0) ? PH_MBODY : PH_DELTA;
        end
      end
      default: begin
        emit = 1'b1;
      end
    endcase

    // track cut off inside an event or right after a delta
    if (last && phase_d != PH_DELTA && phase_d != PH_ERROR) begin
      err_n = ERR_TRUNC;
    end

    err_d = err_n;
    if (last) begin
      phase_d = PH_DELTA;
      hcnt_d  = '0;
      rem_d   = '0;
      err_d   = ERR_NONE;
    end

    job_o.track_last = last;
    job_o.err        = err_n;
    job_o.rewrite    = rewrite;
    if (use_delta) begin
      job_o.bytes    = delta_bytes;
      job_o.last_idx = hcnt_q;
    end else begin
      job_o.bytes    = delta_bytes;
      job_o.bytes[0] = b;
      job_o.last_idx = '0;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      hcnt_q  <= '0;
      rem_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (accept) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_we) begin
      held_q[hcnt_q] <= b;
    end
  end

endmodule

`default_nettype wire

/* design/hmdc_queue.sv */
`default_nettype none

module hmdc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hmdc_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output hmdc_pkg::job_t      head_o
);
  import hmdc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

/* design/hmdc_back.sv */
`default_nettype none

module hmdc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire hmdc_pkg::job_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hmdc_pkg::out_t      out_data_o
);
  import hmdc_pkg::*;

  logic            out_valid_q;
  out_t            out_q, out_d;
  logic [IdxW-1:0] idx_q;
  logic            load;
  logic            fin;
  logic [IdxW-1:0] hi;
  logic [IdxW-1:0] raw_cut;
  logic [IdxW-1:0] grp_sel;
  logic [7:0]      lane_byte;

  assign load = q_valid_i && (!out_valid_q || out_ready_i);
  assign fin  = (idx_q == head_i.last_idx);

  // highest nonzero 7-bit group sets how many midi bytes the delta needs
  always_comb begin
    hi = '0;
    for (int i = 0; i < MaxDeltaBytes; i++) begin
      if (IdxW'(i) <= head_i.last_idx && head_i.bytes[i][6:0] != 7'd0) begin
        hi = IdxW'(i);
      end
    end
  end

  assign raw_cut = head_i.last_idx - hi;
  assign grp_sel = head_i.last_idx - idx_q;

  // in a rewrite, leading bytes pass raw, then groups go out most significant first; other runs pass raw
  always_comb begin
    if (!head_i.rewrite || idx_q < raw_cut) begin
      lane_byte = head_i.bytes[idx_q];
    end else begin
      lane_byte = {!fin, head_i.bytes[grp_sel][6:0]};
    end
    out_d.out_byte    = lane_byte;
    out_d.last_of_run = fin;
    out_d.track_done  = fin && head_i.track_last;
    out_d.error_code  = 3'(head_i.err);
  end

  assign pop_o       = load && fin;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= fin ? '0 : idx_q + IdxW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

/* design/hmdc_checker.sv */
`default_nettype none

module hmdc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire hmdc_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire hmdc_pkg::out_t out_data_o
);
  import hmdc_pkg::*;

  // a stalled transaction stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // track end always closes a run
  a_done_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.track_done |-> out_data_o.last_of_run)
    else $error("track_done without last_of_run");

  a_err_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.error_code <= 3'(ERR_DELTA_LONG))
    else $error("error code out of range");

  // within a run the error code cannot change
  a_err_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run ##1 out_valid_o
    |-> $stable(out_data_o.error_code))
    else $error("error code changed inside a run");

endmodule

bind hmp_to_midi_delta_converter_unit hmdc_checker u_hmdc_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  import hmdc_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 200;
  localparam int unsigned PrintCap = 40;

  // expected byte stream of the converter, kept in step with accepted input
  class delta_rewrite_sb;
    phase_e      phase;
    logic [7:0]  held [MaxDeltaBytes];
    int unsigned held_cnt;
    logic [31:0] remaining;
    err_e        err;
    out_t        expected_q [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      mismatches = 0;
      checked    = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_DELTA;
      held_cnt  = 0;
      remaining = '0;
      err       = ERR_NONE;
      foreach (held[i]) held[i] = '0;
    endfunction

    function void set_error(err_e code);
      err   = code;
      phase = PH_ERROR;
    endfunction

    function void note_input(in_t item);
      logic [7:0]  run [$];
      logic [7:0]  b;
      logic [63:0] dv;
      logic [7:0]  v;
      int unsigned n, m;
      out_t        exp;
      b = item.in_byte;
      case (phase)
        PH_DELTA: begin
          if (!b[7]) begin
            if (held_cnt >= MaxDeltaBytes - 1) begin
              for (int i = 0; i < held_cnt; i++) run.push_back(held[i]);
              held_cnt = 0;
              run.push_back(b);
              set_error(ERR_DELTA_LONG);
            end else begin
              held[held_cnt] = b;
              held_cnt++;
              if (item.track_last) begin
                for (int i = 0; i < held_cnt; i++) run.push_back(held[i]);
                held_cnt = 0;
                set_error(ERR_TRUNC);
              end
            end
          end else begin
            // gather little-endian groups, then re-emit big-endian with padding kept
            dv = '0;
            for (int i = 0; i < held_cnt; i++) dv |= {57'd0, held[i][6:0]} << (7 * i);
            dv |= {57'd0, b[6:0]} << (7 * held_cnt);
            n = held_cnt + 1;
            m = 1;
            while (m < n && (dv >> (7 * m)) != 0) m++;
            for (int i = 0; i < n - m; i++) run.push_back(held[i]);
            for (int k = 0; k < m; k++) begin
              v = {1'b0, dv[7 * (m - 1 - k) +: 7]};
              if (k + 1 < m) v[7] = 1'b1;
              run.push_back(v);
            end
            held_cnt = 0;
            phase    = PH_STATUS;
          end
        end
        PH_STATUS: begin
          run.push_back(b);
          if (b < StatusMin) begin
            set_error(ERR_NO_STATUS);
          end else if (b < SystemMin) begin
            // program change and channel pressure carry one data byte
            remaining = (b[6:4] == 3'd4 || b[6:4] == 3'd5) ? 32'd1 : 32'd2;
            phase     = PH_CHAN;
          end else if (b == MetaStatus) begin
            phase = PH_MTYPE;
          end else begin
            set_error(ERR_SYSEX);
          end
        end
        PH_CHAN, PH_MBODY: begin
          run.push_back(b);
          if (remaining != 0) remaining--;
          if (remaining == 0) phase = PH_DELTA;
        end
        PH_MTYPE: begin
          run.push_back(b);
          remaining = '0;
          phase     = PH_MLEN;
        end
        PH_MLEN: begin
          run.push_back(b);
          remaining = (remaining << 7) + {25'd0, b[6:0]};
          if (!b[7]) phase = (remaining != 0) ? PH_MBODY : PH_DELTA;
        end
        default: begin
          run.push_back(b);
        end
      endcase

      if (item.track_last && phase != PH_DELTA && phase != PH_ERROR) set_error(ERR_TRUNC);

      foreach (run[k]) begin
        exp.out_byte    = run[k];
        exp.last_of_run = (k == run.size() - 1);
        exp.track_done  = (k == run.size() - 1) && item.track_last;
        exp.error_code  = err;
        expected_q.push_back(exp);
      end
      if (item.track_last) clear_state();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < PrintCap)
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 checked, what, got, want);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, out_byte", got.out_byte, 0);
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (got.track_done !== want.track_done)
          report_mismatch("track_done", got.track_done, want.track_done);
        if (got.error_code !== want.error_code)
          report_mismatch("error_code", got.error_code, want.error_code);
      end
      checked++;
    endtask
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic [8:0] ready_tick = '0;

  int unsigned     idle_cycles = 0;
  delta_rewrite_sb sb = new();

  logic [7:0] track_bytes [$];
  in_t        stim_q [$];

  hmp_to_midi_delta_converter_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver cycles through always-ready, coin flip, one-in-four and mostly-ready
  always @(posedge clk) begin
    ready_tick <= ready_tick + 9'd1;
    case (ready_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (ready_tick[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (idle_cycles < StallLimit) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic put(logic [7:0] b);
    track_bytes.push_back(b);
  endtask

  task automatic close_track();
    in_t item;
    foreach (track_bytes[i]) begin
      item.in_byte    = track_bytes[i];
      item.track_last = (i == track_bytes.size() - 1);
      stim_q.push_back(item);
    end
    track_bytes.delete();
  endtask

  // hmp delta: low groups first, the byte with bit 7 set closes it
  task automatic put_delta(int unsigned nbytes);
    for (int i = 0; i < nbytes - 1; i++)
      put($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 127)));
    put($urandom_range(0, 1) ? 8'h80 : 8'($urandom_range(128, 255)));
  endtask

  task automatic put_event();
    int unsigned kind, body;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      put({1'b1, 3'(kind), 4'($urandom_range(0, 15))});
      put(8'($urandom_range(0, 255)));
      if (kind != 4 && kind != 5) put(8'($urandom_range(0, 255)));
    end else begin
      put(MetaStatus);
      put(8'($urandom_range(0, 255)));
      body = $urandom_range(0, 6);
      case ($urandom_range(0, 19))
        0: begin
          // length groups shift past 32 bits and wrap back to zero
          put(8'h90); put(8'h80); put(8'h80); put(8'h80); put(8'h80); put(8'h00);
          body = 0;
        end
        1, 2, 3: begin
          put(8'h80);
          put(8'(body));
        end
        default: put(8'(body));
      endcase
      repeat (body) put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_clean_track();
    repeat ($urandom_range(1, 6)) begin
      put_delta($urandom_range(1, MaxDeltaBytes));
      put_event();
    end
  endtask

  task automatic build_broken_track();
    int unsigned cut;
    case ($urandom_range(0, 4))
      0: begin
        build_clean_track();
        cut = $urandom_range(1, track_bytes.size());
        while (track_bytes.size() > cut) void'(track_bytes.pop_back());
      end
      1: begin
        put_delta($urandom_range(1, 3));
        put(8'($urandom_range(0, 127)));
      end
      2: begin
        put_delta($urandom_range(1, 3));
        put(8'($urandom_range(240, 254)));
      end
      3: repeat ($urandom_range(MaxDeltaBytes, MaxDeltaBytes + 2))
           put(8'($urandom_range(0, 127)));
      default: put(8'($urandom_range(0, 255)));
    endcase
    repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned burst_left, gap, target;

    // single-byte delta, one-data-byte channel event, padded two-byte delta,
    // end-of-track meta with zero length
    put(8'h85); put(8'hc3); put(8'h7f);
    put(8'h00); put(8'h80);
    put(MetaStatus); put(8'h2f); put(8'h00);
    close_track();
    // widest delta with every group set, top channel status
    put(8'h7f); put(8'h7f); put(8'h7f); put(8'h7f); put(8'hff);
    put(8'hef); put(8'h00); put(8'hff);
    close_track();
    // delta one byte too long, ending on the offending byte
    repeat (MaxDeltaBytes) put(8'h00);
    close_track();
    put(8'h80); put(8'h40); close_track();  // data byte where status belongs
    put(8'h80); put(8'hf0); close_track();  // sysex
    put(8'h81); close_track();              // track ends right after a delta
    put(8'h05); close_track();              // track ends inside a delta
    put(8'h80); put(8'h90); close_track();  // track ends inside an event

    target = stim_q.size() + RandomItems;
    while (stim_q.size() < target) begin
      if ($urandom_range(0, 4) != 0) build_clean_track();
      else build_broken_track();
      close_track();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 40);
    while (stim_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      in_data  <= stim_q.pop_front();
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      burst_left--;
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
